/* design/hts_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hts_pkg;

  typedef enum logic [3:0] {
    ST_UNKNOWN = 4'b0001,
    ST_IDLE    = 4'b0010,
    ST_BURNING = 4'b0100,
    ST_LOWV    = 4'b1000
  } state_t;

  localparam logic [1:0] MODE_UNKNOWN = 2'd0;
  localparam logic [1:0] MODE_IDLE    = 2'd1;
  localparam logic [1:0] MODE_BURNING = 2'd2;
  localparam logic [1:0] MODE_LOWV    = 2'd3;

  localparam logic [1:0] CMD_NONE      = 2'd0;
  localparam logic [1:0] CMD_START     = 2'd1;
  localparam logic [1:0] CMD_STOP      = 2'd2;
  localparam logic [1:0] CMD_KEEPALIVE = 2'd3;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_LOW_VOLTAGE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GEN_VOLTAGE    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BURN_TIME      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEEPALIVE_IVL  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHECK_IVL      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_RECOVERY_CHECKS = 3'd5;

  localparam int BURN_LIMIT_W = 24;
  localparam logic [16:0] MS_PER_MINUTE = 17'd60000;

  localparam logic [15:0] LOW_VOLTAGE_RESET   = 16'd11500;
  localparam logic [15:0] GEN_VOLTAGE_RESET   = 16'd13500;
  localparam logic [BURN_LIMIT_W-1:0] BURN_LIMIT_RESET = 24'd1800000;
  localparam logic [15:0] KEEPALIVE_IVL_RESET = 16'd2000;
  localparam logic [15:0] CHECK_IVL_RESET     = 16'd1000;
  localparam logic [2:0]  RECOVERY_RESET      = 3'd5;

  typedef struct packed {
    logic [15:0]             low_voltage_mv;
    logic [15:0]             generator_voltage_mv;
    logic [BURN_LIMIT_W-1:0] burn_limit_ms;
    logic [15:0]             keepalive_interval_ms;
    logic [15:0]             voltage_check_interval_ms;
    logic [2:0]              recovery_checks;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [15:0] voltage_mv;
    logic        target_burning;
    logic        command_ok;
  } item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] command;
  } result_t;

endpackage

`default_nettype wire

/* design/hts_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

module hts_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [hts_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [hts_pkg::CFG_DATA_W-1:0]     cfg_data,
  output hts_pkg::cfg_t                           cfg
);

  logic [24:0] burn_limit_full;

  assign burn_limit_full = {17'd0, cfg_data[7:0]} * {8'd0, hts_pkg::MS_PER_MINUTE};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_voltage_mv            <= hts_pkg::LOW_VOLTAGE_RESET;
      cfg.generator_voltage_mv      <= hts_pkg::GEN_VOLTAGE_RESET;
      cfg.burn_limit_ms             <= hts_pkg::BURN_LIMIT_RESET;
      cfg.keepalive_interval_ms     <= hts_pkg::KEEPALIVE_IVL_RESET;
      cfg.voltage_check_interval_ms <= hts_pkg::CHECK_IVL_RESET;
      cfg.recovery_checks           <= hts_pkg::RECOVERY_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        hts_pkg::CFG_LOW_VOLTAGE:     cfg.low_voltage_mv <= cfg_data;
        hts_pkg::CFG_GEN_VOLTAGE:     cfg.generator_voltage_mv <= cfg_data;
        hts_pkg::CFG_BURN_TIME:
          cfg.burn_limit_ms <= burn_limit_full[hts_pkg::BURN_LIMIT_W-1:0];
        hts_pkg::CFG_KEEPALIVE_IVL:   cfg.keepalive_interval_ms <= cfg_data;
        hts_pkg::CFG_CHECK_IVL:       cfg.voltage_check_interval_ms <= cfg_data;
        hts_pkg::CFG_RECOVERY_CHECKS: cfg.recovery_checks <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/hts_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module hts_core (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     step,
  input  wire hts_pkg::item_t  item,
  input  wire hts_pkg::cfg_t   cfg,
  output hts_pkg::result_t result
);

  hts_pkg::state_t state, state_next;
  logic [31:0] burn_start_ms, burn_start_ms_next;
  logic [31:0] last_keepalive_ms, last_keepalive_ms_next;
  logic [31:0] last_check_ms, last_check_ms_next;
  logic [2:0]  recovery_left, recovery_left_next;

  logic        normal;
  logic [31:0] burn_elapsed;
  logic [31:0] keep_elapsed;
  logic [31:0] check_elapsed;
  logic [1:0]  cmd;

  assign normal        = item.voltage_mv >= cfg.low_voltage_mv;
  assign burn_elapsed  = item.now_ms - burn_start_ms;
  assign keep_elapsed  = item.now_ms - last_keepalive_ms;
  assign check_elapsed = item.now_ms - last_check_ms;

  always_comb begin
    state_next             = state;
    burn_start_ms_next     = burn_start_ms;
    last_keepalive_ms_next = last_keepalive_ms;
    last_check_ms_next     = last_check_ms;
    recovery_left_next     = recovery_left;
    cmd                    = hts_pkg::CMD_NONE;
    unique case (state)
      hts_pkg::ST_UNKNOWN: begin
        state_next = hts_pkg::ST_IDLE;
      end
      hts_pkg::ST_IDLE: begin
        if (item.target_burning && normal) begin
          cmd = hts_pkg::CMD_START;
          if (item.command_ok) begin
            state_next         = hts_pkg::ST_BURNING;
            burn_start_ms_next = item.now_ms;
          end
        end
      end
      hts_pkg::ST_BURNING: begin
        if (!normal || burn_elapsed > {8'd0, cfg.burn_limit_ms} ||
            item.voltage_mv > cfg.generator_voltage_mv || !item.target_burning) begin
          cmd                = hts_pkg::CMD_STOP;
          burn_start_ms_next = 32'd0;
          if (item.command_ok) begin
            state_next = normal ? hts_pkg::ST_IDLE : hts_pkg::ST_LOWV;
          end
        end else if (keep_elapsed >= {16'd0, cfg.keepalive_interval_ms}) begin
          cmd = hts_pkg::CMD_KEEPALIVE;
          if (item.command_ok) begin
            last_keepalive_ms_next = item.now_ms;
          end
        end
      end
      hts_pkg::ST_LOWV: begin
        if (check_elapsed > {16'd0, cfg.voltage_check_interval_ms}) begin
          if (normal) begin
            if (recovery_left != 3'd0) begin
              recovery_left_next = recovery_left - 3'd1;
            end else begin
              state_next         = hts_pkg::ST_IDLE;
              recovery_left_next = cfg.recovery_checks;
            end
            last_check_ms_next = item.now_ms;
          end else begin
            recovery_left_next = cfg.recovery_checks;
          end
        end
      end
      default: begin
        state_next = hts_pkg::ST_UNKNOWN;
      end
    endcase
  end

  always_comb begin
    result.command = cmd;
    unique case (state_next)
      hts_pkg::ST_UNKNOWN: result.mode = hts_pkg::MODE_UNKNOWN;
      hts_pkg::ST_IDLE:    result.mode = hts_pkg::MODE_IDLE;
      hts_pkg::ST_BURNING: result.mode = hts_pkg::MODE_BURNING;
      hts_pkg::ST_LOWV:    result.mode = hts_pkg::MODE_LOWV;
      default:             result.mode = hts_pkg::MODE_UNKNOWN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= hts_pkg::ST_UNKNOWN;
      burn_start_ms     <= 32'd0;
      last_keepalive_ms <= 32'd0;
      last_check_ms     <= 32'd0;
      recovery_left     <= 3'd0;
    end else if (step) begin
      state             <= state_next;
      burn_start_ms     <= burn_start_ms_next;
      last_keepalive_ms <= last_keepalive_ms_next;
      last_check_ms     <= last_check_ms_next;
      recovery_left     <= recovery_left_next;
    end
  end

  a_stop_clears_start: assert property (@(posedge clk) disable iff (rst)
    step && cmd == hts_pkg::CMD_STOP |=> burn_start_ms == 32'd0)
    else $error("burn start time not cleared after a stop");

  a_unknown_to_idle: assert property (@(posedge clk) disable iff (rst)
    step && state == hts_pkg::ST_UNKNOWN |=> state == hts_pkg::ST_IDLE)
    else $error("unknown mode did not move to idle");

  a_hold_without_step: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(state) && $stable(recovery_left) && $stable(last_check_ms))
    else $error("state changed without a transaction");

  a_lowv_exit_idle: assert property (@(posedge clk) disable iff (rst)
    step && state == hts_pkg::ST_LOWV |=>
      state == hts_pkg::ST_LOWV || state == hts_pkg::ST_IDLE)
    else $error("low voltage mode left to a mode other than idle");

  a_keepalive_only_burning: assert property (@(posedge clk) disable iff (rst)
    step && cmd == hts_pkg::CMD_KEEPALIVE |=> state == hts_pkg::ST_BURNING)
    else $error("keepalive check issued outside burning mode");

endmodule

`default_nettype wire

/* design/heater_supervisor_fsm.sv */
// Heater supervisor. Each input transaction is one supervision pass carrying the
// time, the supply voltage, the requested target and the acknowledge of the command
// issued in that pass. Each pass yields exactly one output transaction with the
// mode after the pass and the command issued (none, start, stop or keepalive).
// An accepted pass lands in an input register; the mode logic then evaluates it,
// updates the mode and timers, and loads the result register once that register is
// free. One pass per cycle is sustained while the receiver takes each result.
// When the receiver stalls, the result register holds its transaction and the
// input register takes one more pass; input ready then drops until the result
// is taken. Configuration registers are to be written through cfg_write, cfg_index
// and cfg_data only while no pass is in flight, which the block does not enforce;
// the burn limit in milliseconds is computed at the time of the write. Reset
// restores all register defaults, clears both stages and puts the mode in unknown
// with all timers at zero.
`timescale 1ns / 1ps
`default_nettype none

module heater_supervisor_fsm (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [hts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [hts_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [31:0]                     now_ms,
  input  wire logic [15:0]                     voltage_mv,
  input  wire logic                            target_burning,
  input  wire logic                            command_ok,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [1:0]                           mode,
  output logic [1:0]                           command
);

  hts_pkg::cfg_t    cfg;
  hts_pkg::item_t   item;
  hts_pkg::result_t result;
  logic             item_valid;
  logic             step;

  assign step     = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || step;

  hts_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hts_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.now_ms         <= now_ms;
      item.voltage_mv     <= voltage_mv;
      item.target_burning <= target_burning;
      item.command_ok     <= command_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      mode    <= result.mode;
      command <= result.command;
    end
  end

endmodule

`default_nettype wire

/* bench/tb_heater_supervisor_fsm.sv */
`timescale 1ns / 1ps

module tb_heater_supervisor_fsm;

  localparam int HOLD_OFF_CYCLES = 300;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_write = 1'b0;
  logic [hts_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [hts_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [31:0]                     now_ms = '0;
  logic [15:0]                     voltage_mv = '0;
  logic                            target_burning = 1'b0;
  logic                            command_ok = 1'b0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [1:0]                      mode;
  logic [1:0]                      command;

  heater_supervisor_fsm i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .now_ms(now_ms),
    .voltage_mv(voltage_mv),
    .target_burning(target_burning),
    .command_ok(command_ok),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .mode(mode),
    .command(command)
  );

  // Register shadow copies.
  logic [15:0] cfg_low_mv = hts_pkg::LOW_VOLTAGE_RESET;
  logic [15:0] cfg_gen_mv = hts_pkg::GEN_VOLTAGE_RESET;
  logic [7:0]  cfg_burn_min = 8'd30;
  logic [15:0] cfg_keepalive_ms = hts_pkg::KEEPALIVE_IVL_RESET;
  logic [15:0] cfg_check_ms = hts_pkg::CHECK_IVL_RESET;
  logic [2:0]  cfg_recovery = hts_pkg::RECOVERY_RESET;

  // Supervisor state as the block should hold it.
  logic [1:0]  sup_mode = hts_pkg::MODE_UNKNOWN;
  logic [31:0] burn_start_ms = '0;
  logic [31:0] keepalive_ms = '0;
  logic [31:0] check_ms = '0;
  logic [2:0]  recovery_left = '0;

  hts_pkg::result_t expected_results[$];
  logic [31:0] sim_ms = '0;
  bit          sender_idle_on = 1'b1;
  bit          receiver_idle_on = 1'b1;
  int          hold_request = 0;
  int          mismatch_count = 0;
  int          passes_sent = 0;
  int          results_checked = 0;
  int          settings_used = 1;
  int          starts_seen = 0;
  int          stops_seen = 0;
  int          keepalives_seen = 0;
  int          burn_entries = 0;
  int          lowv_entries = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic hts_pkg::result_t supervise_pass(input hts_pkg::item_t p);
    hts_pkg::result_t r;
    logic [31:0] limit;
    logic [1:0]  next_mode;
    logic [1:0]  cmd;
    logic        normal;
    cmd = hts_pkg::CMD_NONE;
    normal = p.voltage_mv >= cfg_low_mv;
    case (sup_mode)
      hts_pkg::MODE_UNKNOWN: begin
        sup_mode = hts_pkg::MODE_IDLE;
      end
      hts_pkg::MODE_IDLE: begin
        if (p.target_burning && normal) begin
          cmd = hts_pkg::CMD_START;
          if (p.command_ok) begin
            sup_mode = hts_pkg::MODE_BURNING;
            burn_start_ms = p.now_ms;
            burn_entries++;
          end
        end
      end
      hts_pkg::MODE_BURNING: begin
        limit = {24'd0, cfg_burn_min} * 32'd60000;
        next_mode = hts_pkg::MODE_IDLE;
        if (!normal) begin
          cmd = hts_pkg::CMD_STOP;
          next_mode = hts_pkg::MODE_LOWV;
        end else if (32'(p.now_ms - burn_start_ms) > limit) begin
          cmd = hts_pkg::CMD_STOP;
        end else if (p.voltage_mv > cfg_gen_mv) begin
          cmd = hts_pkg::CMD_STOP;
        end else if (!p.target_burning) begin
          cmd = hts_pkg::CMD_STOP;
        end else if (32'(p.now_ms - keepalive_ms) >= {16'd0, cfg_keepalive_ms}) begin
          cmd = hts_pkg::CMD_KEEPALIVE;
          if (p.command_ok) keepalive_ms = p.now_ms;
        end
        if (cmd == hts_pkg::CMD_STOP) begin
          burn_start_ms = '0;
          if (p.command_ok) begin
            sup_mode = next_mode;
            if (next_mode == hts_pkg::MODE_LOWV) lowv_entries++;
          end
        end
      end
      default: begin
        if (32'(p.now_ms - check_ms) > {16'd0, cfg_check_ms}) begin
          if (normal) begin
            if (recovery_left != 3'd0) begin
              recovery_left = recovery_left - 3'd1;
            end else begin
              sup_mode = hts_pkg::MODE_IDLE;
              recovery_left = cfg_recovery;
            end
            check_ms = p.now_ms;
          end else begin
            recovery_left = cfg_recovery;
          end
        end
      end
    endcase
    case (cmd)
      hts_pkg::CMD_START: starts_seen++;
      hts_pkg::CMD_STOP: stops_seen++;
      hts_pkg::CMD_KEEPALIVE: keepalives_seen++;
      default: ;
    endcase
    r.mode = sup_mode;
    r.command = cmd;
    return r;
  endfunction

  task automatic send_pass(input logic [31:0] t, input logic [15:0] v, input logic tgt,
                           input logic ack);
    int             gap;
    hts_pkg::item_t p;
    gap = sender_idle_on ? $urandom_range(0, 17) : 0;
    p.now_ms = t;
    p.voltage_mv = v;
    p.target_burning = tgt;
    p.command_ok = ack;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    now_ms <= t;
    voltage_mv <= v;
    target_burning <= tgt;
    command_ok <= ack;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(supervise_pass(p));
    passes_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [hts_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [15:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      hts_pkg::CFG_LOW_VOLTAGE: cfg_low_mv = value;
      hts_pkg::CFG_GEN_VOLTAGE: cfg_gen_mv = value;
      hts_pkg::CFG_BURN_TIME: cfg_burn_min = value[7:0];
      hts_pkg::CFG_KEEPALIVE_IVL: cfg_keepalive_ms = value;
      hts_pkg::CFG_CHECK_IVL: cfg_check_ms = value;
      hts_pkg::CFG_RECOVERY_CHECKS: cfg_recovery = value[2:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int low, input int gen, input int burn, input int ka,
                            input int chk, input int rec);
    wait_idle();
    write_reg(hts_pkg::CFG_LOW_VOLTAGE, 16'(low));
    write_reg(hts_pkg::CFG_GEN_VOLTAGE, 16'(gen));
    write_reg(hts_pkg::CFG_BURN_TIME, 16'(burn));
    write_reg(hts_pkg::CFG_KEEPALIVE_IVL, 16'(ka));
    write_reg(hts_pkg::CFG_CHECK_IVL, 16'(chk));
    write_reg(hts_pkg::CFG_RECOVERY_CHECKS, 16'(rec));
    settings_used++;
  endtask

  task automatic run_random_passes(input int count);
    int          lo;
    int          hi;
    logic [31:0] step;
    logic [15:0] v;
    repeat (count) begin
      case ($urandom_range(0, 19))
        0: step = 0;
        1, 2, 3, 4, 5, 6, 7: step = $urandom_range(1, 300);
        8, 9, 10, 11, 12, 13: step = $urandom_range(300, 4000);
        14, 15, 16, 17: step = $urandom_range(4000, 120000);
        18: step = $urandom_range(100000, 2000000);
        default: step = $urandom();
      endcase
      sim_ms = sim_ms + step;
      lo = cfg_low_mv;
      hi = cfg_gen_mv;
      case ($urandom_range(0, 15))
        0: v = (lo > 0) ? 16'(lo - 1) : 16'd0;
        1: v = 16'(lo);
        2: v = 16'(hi);
        3: v = (hi < 65535) ? 16'(hi + 1) : 16'hFFFF;
        4: v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        5: v = 16'($urandom_range(0, 65535));
        6: v = 16'($urandom_range(0, lo));
        default: v = 16'($urandom_range(lo, hi));
      endcase
      send_pass(sim_ms, v, $urandom_range(0, 7) != 0, $urandom_range(0, 4) != 0);
    end
  endtask

  task automatic test_directed_reset_defaults();
    send_pass(32'd0, 16'd12000, 1'b1, 1'b1);
    send_pass(32'hFFFF_FFFF, 16'd11499, 1'b1, 1'b1);
    send_pass(32'd20, 16'd12000, 1'b0, 1'b1);
    send_pass(32'd30, 16'hFFFF, 1'b1, 1'b0);
    send_pass(32'd1000, 16'd11500, 1'b1, 1'b1);
    send_pass(32'd1999, 16'd12000, 1'b1, 1'b1);
    send_pass(32'd2000, 16'd12000, 1'b1, 1'b0);
    send_pass(32'd2001, 16'd12000, 1'b1, 1'b1);
    send_pass(32'd2002, 16'd13500, 1'b1, 1'b1);
    send_pass(32'd2003, 16'd13501, 1'b1, 1'b0);
    send_pass(32'd2004, 16'd12000, 1'b0, 1'b1);
    // The burn starts just before the time counter wraps.
    send_pass(32'hFFFF_FF00, 16'd12000, 1'b1, 1'b1);
    send_pass(32'h0000_0100, 16'd12000, 1'b1, 1'b1);
    send_pass(32'd1799744, 16'd12000, 1'b1, 1'b0);
    send_pass(32'd1799745, 16'd12000, 1'b1, 1'b1);
    send_pass(32'd1800000, 16'd12000, 1'b1, 1'b1);
    send_pass(32'd1800100, 16'd0, 1'b1, 1'b1);
    send_pass(32'd1801000, 16'd11499, 1'b1, 1'b1);
    send_pass(32'd1802000, 16'd12000, 1'b1, 1'b1);
    send_pass(32'd1803000, 16'd12000, 1'b1, 1'b1);
    send_pass(32'd1803001, 16'd12000, 1'b1, 1'b1);
    send_pass(32'd1804002, 16'd12000, 1'b1, 1'b1);
    send_pass(32'd1805003, 16'd12000, 1'b1, 1'b1);
    send_pass(32'd1806004, 16'd12000, 1'b1, 1'b1);
    send_pass(32'd1807005, 16'd12000, 1'b1, 1'b1);
    sim_ms = 32'd1807005;
  endtask

  task automatic test_typical_settings();
    repeat (3) begin
      set_config($urandom_range(10500, 12000), $urandom_range(13000, 14500),
                 $urandom_range(1, 3), $urandom_range(200, 3000),
                 $urandom_range(100, 2000), $urandom_range(0, 7));
      run_random_passes(120);
    end
  endtask

  task automatic test_extreme_settings();
    set_config(0, 65535, 255, 65535, 65535, 7);
    run_random_passes(80);
    set_config(65535, 0, 0, 0, 0, 0);
    run_random_passes(80);
    set_config(11500, 13500, 0, 0, 0, 0);
    run_random_passes(80);
  endtask

  task automatic test_random_settings();
    sender_idle_on = 1'b0;
    receiver_idle_on = 1'b0;
    set_config($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 255),
               $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 7));
    run_random_passes(120);
    sender_idle_on = 1'b1;
    receiver_idle_on = 1'b1;
    set_config($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 255),
               $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 7));
    run_random_passes(120);
  endtask

  task automatic test_receiver_backpressure();
    set_config(11500, 13500, 1, 500, 300, 2);
    sender_idle_on = 1'b0;
    hold_request = HOLD_OFF_CYCLES;
    run_random_passes(100);
    sender_idle_on = 1'b1;
  endtask

  // Result side: random stalls, long hold-offs on request, and the check of each transaction.
  initial begin
    int               stall;
    hts_pkg::result_t exp_r;
    wait (!rst);
    forever begin
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end else begin
        stall = receiver_idle_on ? $urandom_range(0, 17) : 0;
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction: mode %0d, command %0d", mode, command);
        mismatch_count++;
      end else begin
        exp_r = expected_results.pop_front();
        results_checked++;
        if (mode !== exp_r.mode) begin
          $error("mode: expected %0d, actual %0d", exp_r.mode, mode);
          mismatch_count++;
        end
        if (command !== exp_r.command) begin
          $error("command: expected %0d, actual %0d", exp_r.command, command);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_reset_defaults();
    test_typical_settings();
    test_extreme_settings();
    test_random_settings();
    test_receiver_backpressure();
    wait_idle();
    $display("Ran %0d passes under %0d register settings, %0d results checked.",
             passes_sent, settings_used, results_checked);
    $display("Saw %0d starts, %0d stops, %0d keepalives, %0d burns, %0d low-voltage entries.",
             starts_seen, stops_seen, keepalives_seen, burn_entries, lowv_entries);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* heater_supervisor_fsm.f */
design/hts_pkg.sv
design/hts_cfg.sv
design/hts_core.sv
design/heater_supervisor_fsm.sv
bench/tb_heater_supervisor_fsm.sv
